### design/srot_pkg.sv
// ----------------------------------------------------------------------------
// srot_pkg: shared types and constants of the shift/rotate unit
// Operation and size codes, request/response words, the per-stage control
// word and small helpers that depend on the operand size.
// ----------------------------------------------------------------------------
package srot_pkg;

	// Operation codes (req_type)
	localparam logic [3:0] OP_ROL  = 4'd0;
	localparam logic [3:0] OP_ROR  = 4'd1;
	localparam logic [3:0] OP_RCL  = 4'd2;
	localparam logic [3:0] OP_RCR  = 4'd3;
	localparam logic [3:0] OP_SHL  = 4'd4;
	localparam logic [3:0] OP_SHR  = 4'd5;
	localparam logic [3:0] OP_SAR  = 4'd6;
	localparam logic [3:0] OP_SHLD = 4'd7;
	localparam logic [3:0] OP_SHRD = 4'd8;

	// Operand size codes (size_code)
	localparam logic [1:0] SZ_8  = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;
	localparam logic [1:0] SZ_32 = 2'd2;
	localparam logic [1:0] SZ_64 = 2'd3;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [1:0]  size_code;
		logic [63:0] dest_value;
		logic [63:0] source_value;
		logic [7:0]  shift_count;
		logic        cf_in;
		logic        of_in;
		logic        sf_in;
		logic        zf_in;
		logic        pf_in;
	} srot_req_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic        write_back;
		logic        cf_out;
		logic        of_out;
		logic        sf_out;
		logic        zf_out;
		logic        pf_out;
		logic        status;
	} srot_rsp_t;

	// Control word that travels beside the funnel data through the pipe
	typedef struct packed {
		logic [3:0]  op;
		logic [1:0]  size;
		logic        nop;       // no write: bad request, zero count or RCL/RCR count reduced to zero
		logic        bad;       // invalid request
		logic        left;      // result sits at out[W-1:0], else at out[W:1]
		logic        zero_res;  // count at or past the width on SHL/SHLD/SHRD
		logic        zero_cf;   // count past the width on SHL/SHLD/SHRD
		logic        cnt_one;
		logic        dest_msb;
		logic        cf;
		logic        of;
		logic        sf;
		logic        zf;
		logic        pf;
		logic [63:0] dest;
	} srot_ctl_t;

	function automatic logic [63:0] size_mask(input logic [1:0] sz);
		logic [63:0] m;
		unique case (sz)
			SZ_8:    m = 64'h0000_0000_0000_00FF;
			SZ_16:   m = 64'h0000_0000_0000_FFFF;
			SZ_32:   m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [6:0] size_bits(input logic [1:0] sz);
		return 7'd8 << sz;
	endfunction

	function automatic logic msb_of(input logic [63:0] v, input logic [1:0] sz);
		logic b;
		unique case (sz)
			SZ_8:    b = v[7];
			SZ_16:   b = v[15];
			SZ_32:   b = v[31];
			default: b = v[63];
		endcase
		return b;
	endfunction

	function automatic logic nmsb_of(input logic [63:0] v, input logic [1:0] sz);
		logic b;
		unique case (sz)
			SZ_8:    b = v[6];
			SZ_16:   b = v[14];
			SZ_32:   b = v[30];
			default: b = v[62];
		endcase
		return b;
	endfunction

endpackage

### design/x86_shift_rotate_unit.sv
// Each accepted request word is registered in the decode, byte-shift, bit-shift and output stages.
// Throughput: one word per cycle unless stalled; every stage is a plain register, so the
//   byte/bit split of the 128-bit funnel shifter sets the stage depth.
// Stall: all stages hold together while the response word waits for rsp_ready.
// Reset: arst_n clears every stage valid bit at once; data registers keep
//   whatever they held.
// ----------------------------------------------------------------------------
// x86_shift_rotate_unit: pipelined x86 shift/rotate with flags
// ROL, ROR, RCL, RCR, SHL, SHR, SAR, SHLD and SHRD at 8 to 64 bits, each
// mapped onto one right funnel shift of a 128-bit word.
// ----------------------------------------------------------------------------
module x86_shift_rotate_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  srot_pkg::srot_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output srot_pkg::srot_rsp_t rsp
);
	import srot_pkg::*;

	// Stage 1: decode to funnel word + shift amount
	// Stage 2: shift by whole bytes
	// Stage 3: shift by the remaining 0..7 bits
	// Stage 4: result window, special cases, flags; output register

	logic         adv;
	logic         v_s1;
	logic [127:0] f_s1;
	logic [5:0]   a_s1;
	srot_ctl_t    ctl_s1;
	logic         v_s3;
	logic [64:0]  o_s3;
	srot_ctl_t    ctl_s3;

	// Advance the whole pipe when the output register is empty or drains
	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	srot_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (req_valid),
		.req       (req),
		.v_s1      (v_s1),
		.f_s1      (f_s1),
		.a_s1      (a_s1),
		.ctl_s1    (ctl_s1)
	);

	srot_shift u_shift (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_s1   (v_s1),
		.f_s1   (f_s1),
		.a_s1   (a_s1),
		.ctl_s1 (ctl_s1),
		.v_s3   (v_s3),
		.o_s3   (o_s3),
		.ctl_s3 (ctl_s3)
	);

	// Final stage drives the response word directly
	srot_flags u_flags (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_s3   (v_s3),
		.o_s3   (o_s3),
		.ctl_s3 (ctl_s3),
		.v_s4   (rsp_valid),
		.rsp_s4 (rsp)
	);

endmodule

### design/srot_decode.sv
// ----------------------------------------------------------------------------
// srot_decode: request decode, stage 1
// Masks operands and count, reduces the count, and builds the 128-bit funnel
// word and the right-shift amount that turn every operation into one shift.
// ----------------------------------------------------------------------------
module srot_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                req_valid,
	input  srot_pkg::srot_req_t req,
	output logic                v_s1,
	output logic [127:0]        f_s1,
	output logic [5:0]          a_s1,
	output srot_pkg::srot_ctl_t ctl_s1
);
	import srot_pkg::*;

	logic [63:0]  mask;
	logic [6:0]   wbits;
	logic [63:0]  d;
	logic [63:0]  s;
	logic [3:0]   op;
	logic [1:0]   sz;
	logic         dbl;
	logic         rcx;
	logic         bad;
	logic [5:0]   cnt;
	logic [5:0]   rc;
	logic [6:0]   c7;
	logic         over;
	logic         beyond;
	logic [63:0]  rep;
	logic [64:0]  x65;
	logic [127:0] xx;
	logic [63:0]  sx;
	logic [63:0]  sdl_lo;
	logic [63:0]  sdr_lo;
	logic [127:0] f;
	logic [6:0]   am;
	srot_ctl_t    ctl;

	always_comb begin
		op     = req.req_type;
		sz     = req.size_code;
		mask   = size_mask(sz);
		wbits  = size_bits(sz);
		d      = req.dest_value & mask;
		s      = req.source_value & mask;
		dbl    = (op == OP_SHLD) || (op == OP_SHRD);
		rcx    = (op == OP_RCL) || (op == OP_RCR);
		bad    = (op > OP_SHRD) || (dbl && (sz == SZ_8));
		cnt    = (sz == SZ_64) ? req.shift_count[5:0] : {1'b0, req.shift_count[4:0]};
		c7     = {1'b0, cnt};
		over   = c7 >= wbits;
		beyond = c7 > wbits;

		// rotate-through-carry period is W+1: reduce mod 9 or mod 17
		unique case (sz)
			SZ_8: begin
				priority if (cnt >= 6'd27) rc = cnt - 6'd27;
				else if (cnt >= 6'd18)     rc = cnt - 6'd18;
				else if (cnt >= 6'd9)      rc = cnt - 6'd9;
				else                       rc = cnt;
			end
			SZ_16:   rc = (cnt >= 6'd17) ? cnt - 6'd17 : cnt;
			default: rc = cnt;
		endcase

		// operand repeated over 64 bits: rotating it rotates the W-bit value
		unique case (sz)
			SZ_8:    rep = {8{d[7:0]}};
			SZ_16:   rep = {4{d[15:0]}};
			SZ_32:   rep = {2{d[31:0]}};
			default: rep = d;
		endcase

		// {CF, d} repeated with period W+1
		x65    = {1'b0, d} | ({64'b0, req.cf_in} << wbits);
		xx     = {63'b0, x65} | ({63'b0, x65} << (wbits + 7'd1));
		sx     = d | (msb_of(d, sz) ? ~mask : 64'b0);
		sdl_lo = s | (d << wbits);
		sdr_lo = d | (s << wbits);

		unique case (op)
			OP_ROL:  f = {rep, rep};
			OP_ROR:  f = {rep, rep};
			OP_RCL:  f = xx;
			OP_RCR:  f = xx;
			OP_SHL:  f = (sz == SZ_64) ? {d, 64'b0} : {64'b0, d << wbits};
			OP_SHR:  f = {64'b0, d};
			OP_SAR:  f = {(msb_of(d, sz) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'b0), sx};
			OP_SHLD: f = (sz == SZ_64) ? {d, s} : {64'b0, sdl_lo};
			OP_SHRD: f = (sz == SZ_64) ? {s, d} : {64'b0, sdr_lo};
			default: f = '0;
		endcase

		// right-shift amount; right-type ops shift by one less to expose CF
		unique case (op)
			OP_ROL:  am = 7'd64 - c7;
			OP_RCL:  am = wbits - {1'b0, rc};
			OP_RCR:  am = {1'b0, rc} - 7'd1;
			OP_SHL:  am = beyond ? 7'd0 : wbits - c7;
			OP_SHLD: am = beyond ? 7'd0 : wbits - c7;
			default: am = c7 - 7'd1;
		endcase

		ctl.op       = op;
		ctl.size     = sz;
		ctl.bad      = bad;
		ctl.nop      = bad || (cnt == 6'd0) || (rcx && (rc == 6'd0));
		ctl.left     = (op == OP_ROL) || (op == OP_SHL) || (op == OP_SHLD);
		ctl.zero_res = ((op == OP_SHL) || dbl) && over;
		ctl.zero_cf  = ((op == OP_SHL) || dbl) && beyond;
		ctl.cnt_one  = cnt == 6'd1;
		ctl.dest_msb = msb_of(d, sz);
		ctl.cf       = req.cf_in;
		ctl.of       = req.of_in;
		ctl.sf       = req.sf_in;
		ctl.zf       = req.zf_in;
		ctl.pf       = req.pf_in;
		ctl.dest     = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1   <= f;
			a_s1   <= am[5:0];
			ctl_s1 <= ctl;
		end
	end

endmodule

### design/srot_shift.sv
// ----------------------------------------------------------------------------
// srot_shift: funnel shifter, stages 2 and 3
// Shifts the 128-bit funnel word right by whole bytes, then by 0 to 7 bits,
// and keeps the low 65 bits.
// ----------------------------------------------------------------------------
module srot_shift (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                v_s1,
	input  logic [127:0]        f_s1,
	input  logic [5:0]          a_s1,
	input  srot_pkg::srot_ctl_t ctl_s1,
	output logic                v_s3,
	output logic [64:0]         o_s3,
	output srot_pkg::srot_ctl_t ctl_s3
);
	import srot_pkg::*;

	logic        v_s2;
	logic [71:0] t_s2;
	logic [2:0]  fa_s2;
	srot_ctl_t   ctl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2   <= 72'(f_s1 >> {a_s1[5:3], 3'b000});
			fa_s2  <= a_s1[2:0];
			ctl_s2 <= ctl_s1;
			o_s3   <= 65'(t_s2 >> fa_s2);
			ctl_s3 <= ctl_s2;
		end
	end

endmodule

### design/srot_flags.sv
// ----------------------------------------------------------------------------
// srot_flags: result select and flag update, stage 4
// Picks the result window, applies the special cases and forms CF, OF, SF,
// ZF and PF; its register is the output word.
// ----------------------------------------------------------------------------
module srot_flags (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                v_s3,
	input  logic [64:0]         o_s3,
	input  srot_pkg::srot_ctl_t ctl_s3,
	output logic                v_s4,
	output srot_pkg::srot_rsp_t rsp_s4
);
	import srot_pkg::*;

	logic [63:0] mask;
	logic [63:0] res_raw;
	logic [63:0] res;
	logic        msb;
	logic        nmsb;
	logic        cf_left;
	logic        cf_n;
	logic        of_n;
	srot_rsp_t   rsp;

	always_comb begin
		mask    = size_mask(ctl_s3.size);
		res_raw = ctl_s3.left ? o_s3[63:0] : o_s3[64:1];
		res     = ctl_s3.zero_res ? 64'b0 : (res_raw & mask);
		msb     = msb_of(res, ctl_s3.size);
		nmsb    = nmsb_of(res, ctl_s3.size);

		// last bit out of a left shift sits just above the result window
		unique case (ctl_s3.size)
			SZ_8:    cf_left = o_s3[8];
			SZ_16:   cf_left = o_s3[16];
			SZ_32:   cf_left = o_s3[32];
			default: cf_left = o_s3[64];
		endcase

		unique case (ctl_s3.op)
			OP_ROL: begin
				cf_n = res[0];
				of_n = msb ^ res[0];
			end
			OP_ROR: begin
				cf_n = msb;
				of_n = msb ^ nmsb;
			end
			OP_RCL: begin
				cf_n = o_s3[0];
				of_n = msb ^ o_s3[0];
			end
			OP_RCR: begin
				cf_n = o_s3[0];
				of_n = msb ^ nmsb;
			end
			OP_SHL: begin
				cf_n = ctl_s3.zero_cf ? 1'b0 : cf_left;
				of_n = msb ^ cf_n;
			end
			OP_SHR: begin
				cf_n = o_s3[0];
				of_n = ctl_s3.dest_msb;
			end
			OP_SAR: begin
				cf_n = o_s3[0];
				of_n = 1'b0;
			end
			OP_SHLD: begin
				cf_n = ctl_s3.zero_cf ? 1'b0 : cf_left;
				of_n = msb ^ ctl_s3.dest_msb;
			end
			OP_SHRD: begin
				cf_n = ctl_s3.zero_cf ? 1'b0 : o_s3[0];
				of_n = msb ^ ctl_s3.dest_msb;
			end
			default: begin
				cf_n = ctl_s3.cf;
				of_n = ctl_s3.of;
			end
		endcase

		rsp.result_value = ctl_s3.dest;
		rsp.write_back   = 1'b0;
		rsp.cf_out       = ctl_s3.cf;
		rsp.of_out       = ctl_s3.of;
		rsp.sf_out       = ctl_s3.sf;
		rsp.zf_out       = ctl_s3.zf;
		rsp.pf_out       = ctl_s3.pf;
		rsp.status       = ctl_s3.bad;
		if (!ctl_s3.nop) begin
			rsp.result_value = res;
			rsp.write_back   = 1'b1;
			rsp.cf_out       = cf_n;
			if (ctl_s3.cnt_one) begin
				rsp.of_out = of_n;
			end
			if (ctl_s3.op >= OP_SHL) begin
				rsp.sf_out = msb;
				rsp.zf_out = res == 64'b0;
				rsp.pf_out = ~^res[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s4 <= rsp;
		end
	end

endmodule

### design/srot_checker.sv
// ----------------------------------------------------------------------------
// srot_checker: port-level checks of the shift/rotate unit
// Watches the handshake and response word on the top-level ports.
// ----------------------------------------------------------------------------
module srot_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input srot_pkg::srot_rsp_t rsp
);
	import srot_pkg::*;

	// Hold a stalled response word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// Take a request only when the output stage can move
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready))
		else $error("req_ready out of step with output stall");

	// Drop the write on an invalid request
	a_bad_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> !rsp.write_back)
		else $error("write_back set on invalid request");

	// Keep the output empty on the first edge after reset is released
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("response valid right after reset");

endmodule

bind x86_shift_rotate_unit srot_checker u_srot_checker (.*);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the x86 shift/rotate unit
// Sends directed corner words and random shift/rotate words through the
// request channel with random gaps and response stalls. Each accepted word
// gets a predicted response from a behavioral model of the x86 semantics,
// and every response word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import srot_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 7;
	localparam int PIPE_LATENCY = 4;
	localparam int IDLE_LIMIT   = 1000;
	localparam int HOLD_CYCLES  = 80;
	localparam int MAX_GAP      = 9;
	localparam int MAX_PRINTED  = 100;

	// Count masking and the rotate-through-carry modulus at the small sizes
	localparam int unsigned COUNT_MASK    = 31;
	localparam int unsigned COUNT_MASK_64 = 63;
	localparam int unsigned RC_MOD_8      = 9;
	localparam int unsigned RC_MOD_16     = 17;

	// Operation codes past SHRD that the unit must reject
	localparam logic [3:0] OP_UNUSED_LO = 4'd9;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;

	// Incoming flag sets, ordered {cf, of, sf, zf, pf}
	localparam logic [4:0] FLAGS_CLEAR = 5'b00000;
	localparam logic [4:0] FLAGS_SET   = 5'b11111;
	localparam logic [4:0] FLAGS_CF    = 5'b10000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	srot_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	srot_rsp_t rsp;

	srot_rsp_t pending_rsp[$];   // predicted response words, oldest first
	int        errors    = 0;
	int        rsp_count = 0;
	bit        tx_quiet  = 1'b0; // sender sends back to back
	logic      rx_quiet  = 1'b0; // receiver never stalls
	logic      rx_block  = 1'b0; // receiver holds off completely
	int        rx_wait   = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	x86_shift_rotate_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// ------------------------------------------------------------------
	// Behavioral prediction of one shift/rotate word
	// ------------------------------------------------------------------
	function automatic logic bit_of(input logic [63:0] v, input int unsigned pos);
		return v[pos & 63];
	endfunction

	function automatic srot_rsp_t predict_shift(input srot_req_t w);
		srot_rsp_t   r;
		int unsigned width, cnt, rc, i;
		logic [63:0] mask, d, s, res, v;
		logic        cf, of, sf, zf, pf, c, nc, upd_szp, no_write;
		width    = 8 << w.size_code;
		mask     = {64{1'b1}} >> (64 - width);
		d        = w.dest_value & mask;
		s        = w.source_value & mask;
		{cf, of, sf, zf, pf} = {w.cf_in, w.of_in, w.sf_in, w.zf_in, w.pf_in};
		res      = d;
		upd_szp  = 1'b0;
		no_write = 1'b0;
		r        = '0;
		cnt      = w.shift_count & ((w.size_code == SZ_64) ? COUNT_MASK_64 : COUNT_MASK);

		// Reject double shifts at 8 bits and undefined codes; pass flags through
		if (w.req_type > OP_SHRD || (w.req_type >= OP_SHLD && w.size_code == SZ_8)) begin
			r.status = 1'b1;
			no_write = 1'b1;
		end else if (cnt == 0) begin
			no_write = 1'b1;
		end else begin
			case (w.req_type)
				OP_ROL: begin
					rc = cnt % width;
					if (rc != 0)
						res = ((d << rc) | (d >> (width - rc))) & mask;
					cf = res[0];
					if (cnt == 1)
						of = bit_of(res, width - 1) ^ cf;
				end
				OP_ROR: begin
					rc = cnt % width;
					if (rc != 0)
						res = ((d >> rc) | (d << (width - rc))) & mask;
					cf = bit_of(res, width - 1);
					if (cnt == 1)
						of = bit_of(res, width - 1) ^ bit_of(res, width - 2);
				end
				OP_RCL, OP_RCR: begin
					rc = (w.size_code == SZ_8) ? cnt % RC_MOD_8 :
						(w.size_code == SZ_16) ? cnt % RC_MOD_16 : cnt;
					if (rc == 0) begin
						no_write = 1'b1;
					end else begin
						c = cf;
						v = d;
						// Walk the carry through the operand one position at a time
						for (i = 0; i < rc; i++) begin
							if (w.req_type == OP_RCL) begin
								nc = bit_of(v, width - 1);
								v  = ((v << 1) | 64'(c)) & mask;
							end else begin
								nc = v[0];
								v  = ((v >> 1) | (64'(c) << (width - 1))) & mask;
							end
							c = nc;
						end
						cf  = c;
						res = v;
						if (cnt == 1) begin
							if (w.req_type == OP_RCL)
								of = bit_of(res, width - 1) ^ cf;
							else
								of = bit_of(res, width - 1) ^ bit_of(res, width - 2);
						end
					end
				end
				OP_SHL: begin
					res = (cnt >= width) ? 64'h0 : ((d << cnt) & mask);
					cf  = (cnt <= width) ? bit_of(d, width - cnt) : 1'b0;
					if (cnt == 1)
						of = bit_of(res, width - 1) ^ cf;
					upd_szp = 1'b1;
				end
				OP_SHR: begin
					cf  = (cnt <= width) ? bit_of(d, cnt - 1) : 1'b0;
					res = (cnt >= width) ? 64'h0 : (d >> cnt);
					if (cnt == 1)
						of = bit_of(d, width - 1);
					upd_szp = 1'b1;
				end
				OP_SAR: begin
					cf = (cnt <= width) ? bit_of(d, cnt - 1) : bit_of(d, width - 1);
					if (cnt >= width) begin
						res = bit_of(d, width - 1) ? mask : 64'h0;
					end else begin
						res = d >> cnt;
						if (bit_of(d, width - 1))
							res |= (mask << (width - cnt)) & mask;
					end
					if (cnt == 1)
						of = 1'b0;
					upd_szp = 1'b1;
				end
				OP_SHLD, OP_SHRD: begin
					if (cnt >= width)
						res = 64'h0;
					else if (w.req_type == OP_SHLD)
						res = ((d << cnt) | (s >> (width - cnt))) & mask;
					else
						res = ((d >> cnt) | (s << (width - cnt))) & mask;
					if (w.req_type == OP_SHLD)
						cf = (cnt <= width) ? bit_of(d, width - cnt) : 1'b0;
					else
						cf = (cnt <= width) ? bit_of(d, cnt - 1) : 1'b0;
					if (cnt == 1)
						of = bit_of(res, width - 1) ^ bit_of(d, width - 1);
					upd_szp = 1'b1;
				end
				default: ;
			endcase
		end

		// Shifts refresh SF/ZF/PF from the result; rotates keep them
		if (upd_szp) begin
			sf = bit_of(res, width - 1);
			zf = (res == 64'h0);
			pf = ~^res[7:0];
		end
		r.result_value = res & mask;
		r.write_back   = !no_write;
		r.cf_out       = cf;
		r.of_out       = of;
		r.sf_out       = sf;
		r.zf_out       = zf;
		r.pf_out       = pf;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Word construction
	// ------------------------------------------------------------------
	function automatic srot_req_t make_word(input logic [3:0] op, input logic [1:0] size,
			input logic [63:0] d, input logic [63:0] s, input logic [7:0] cnt,
			input logic [4:0] flags);
		srot_req_t w;
		w.req_type     = op;
		w.size_code    = size;
		w.dest_value   = d;
		w.source_value = s;
		w.shift_count  = cnt;
		{w.cf_in, w.of_in, w.sf_in, w.zf_in, w.pf_in} = flags;
		return w;
	endfunction

	function automatic logic [63:0] random_operand();
		logic [63:0] v;
		case ($urandom_range(0, 4))
			0:       v = {64{1'b1}};
			1:       v = 64'h1 << $urandom_range(0, 63);
			2:       v = ~(64'h1 << $urandom_range(0, 63));
			3:       v = {32'h0, 32'($urandom)};
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic srot_req_t random_word();
		srot_req_t   w;
		int unsigned width;
		// Mostly legal operations; now and then any 4-bit code
		if ($urandom_range(0, 9) == 0)
			w.req_type = 4'($urandom);
		else
			w.req_type = 4'($urandom_range(OP_ROL, OP_SHRD));
		w.size_code    = 2'($urandom);
		width          = 8 << w.size_code;
		w.dest_value   = random_operand();
		w.source_value = random_operand();
		// Favor count 1, tiny counts and counts around the operand width
		case ($urandom_range(0, 5))
			0:       w.shift_count = 8'd1;
			1:       w.shift_count = 8'($urandom_range(0, 3));
			2:       w.shift_count = 8'(width - 1 + $urandom_range(0, 2));
			default: w.shift_count = 8'($urandom);
		endcase
		{w.cf_in, w.of_in, w.sf_in, w.zf_in, w.pf_in} = 5'($urandom);
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// Offer one word after a random gap and hold it until taken. Valid stays
	// high on return so a following word with no gap goes out back to back.
	task automatic send_word(input srot_req_t w);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		pending_rsp.push_back(predict_shift(w));
	endtask

	// Drop valid and hold until every predicted word has come back
	task automatic wait_for_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Response side: stall a random number of cycles after each word
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || rx_block) begin
			rsp_ready <= 1'b0;
			rx_wait = 0;
		end else if (rsp_ready && rsp_valid) begin
			rx_wait = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
			rsp_ready <= (rx_wait == 0);
		end else if (rx_wait != 0) begin
			rx_wait--;
			rsp_ready <= (rx_wait == 0);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		if (errors < MAX_PRINTED)
			$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s got %0h want %0h",
				rsp_count, name, got, want));
	endtask

	// Compare each taken response word with the oldest prediction
	always @(posedge clk) begin : rsp_check
		srot_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("word %0d arrived with nothing pending", rsp_count));
			end else begin
				want = pending_rsp.pop_front();
				check_field("result_value", rsp.result_value, want.result_value);
				check_field("write_back", 64'(rsp.write_back), 64'(want.write_back));
				check_field("cf_out", 64'(rsp.cf_out), 64'(want.cf_out));
				check_field("of_out", 64'(rsp.of_out), 64'(want.of_out));
				check_field("sf_out", 64'(rsp.sf_out), 64'(want.sf_out));
				check_field("zf_out", 64'(rsp.zf_out), 64'(want.zf_out));
				check_field("pf_out", 64'(rsp.pf_out), 64'(want.pf_out));
				check_field("status", 64'(rsp.status), 64'(want.status));
			end
			rsp_count++;
		end
	end

	// Abort when neither channel moves a word for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Corner words: every operation, count edges and the rejected requests
	task automatic test_directed_cases();
		// count 1 forms of ROL, ROR and RCL, with the OF update
		send_word(make_word(OP_ROL, SZ_8,  64'h81, 64'h0, 8'd1, FLAGS_CLEAR));
		send_word(make_word(OP_ROR, SZ_16, 64'h8001, 64'h0, 8'd1, FLAGS_SET));
		send_word(make_word(OP_RCL, SZ_8,  64'h80, 64'h0, 8'd1, FLAGS_CF));
		// rotate through carry: counts that fold to zero, then full 32- and 64-bit counts
		send_word(make_word(OP_RCR, SZ_16, 64'h0001, 64'h0, 8'd17, FLAGS_CF));
		send_word(make_word(OP_RCL, SZ_8,  64'hFF, 64'h0, 8'd9, FLAGS_SET));
		send_word(make_word(OP_RCR, SZ_32, 64'hFFFF_FFFF, 64'h0, 8'd31, FLAGS_CLEAR));
		send_word(make_word(OP_RCL, SZ_64, {64{1'b1}}, 64'h0, 8'd63, FLAGS_CF));
		// plain shifts at and past the width, and SAR at count 1
		send_word(make_word(OP_SHL, SZ_8,  64'h81, 64'h0, 8'd8, FLAGS_CLEAR));
		send_word(make_word(OP_SHL, SZ_8,  64'h81, 64'h0, 8'd9, FLAGS_SET));
		send_word(make_word(OP_SHR, SZ_16, 64'h8000, 64'h0, 8'd16, FLAGS_CLEAR));
		send_word(make_word(OP_SHR, SZ_16, 64'hFFFF, 64'h0, 8'd31, FLAGS_CLEAR));
		send_word(make_word(OP_SAR, SZ_8,  64'h80, 64'h0, 8'd12, FLAGS_CLEAR));
		send_word(make_word(OP_SAR, SZ_16, 64'h7FFF, 64'h0, 8'd20, FLAGS_SET));
		send_word(make_word(OP_SAR, SZ_64, 64'h8000_0000_0000_0000, 64'h0, 8'd1, FLAGS_SET));
		// double shifts: count at or past the width, OF at count 1, full width
		send_word(make_word(OP_SHLD, SZ_16, 64'h8000, 64'hFFFF, 8'd16, FLAGS_CLEAR));
		send_word(make_word(OP_SHRD, SZ_16, 64'h1234, 64'hABCD, 8'd20, FLAGS_CLEAR));
		send_word(make_word(OP_SHLD, SZ_32, 64'h4000_0000, 64'h8000_0000, 8'd1, FLAGS_CLEAR));
		send_word(make_word(OP_SHRD, SZ_64, 64'h1, {64{1'b1}}, 8'd63, FLAGS_CLEAR));
		// rejected: double shift at 8 bits, and the unused codes
		send_word(make_word(OP_SHLD, SZ_8, 64'hA5, 64'h5A, 8'd3, FLAGS_SET));
		send_word(make_word(OP_SHRD, SZ_8, 64'h5A, 64'hA5, 8'd0, FLAGS_CLEAR));
		send_word(make_word(OP_UNUSED_LO, SZ_32, 64'hDEAD_BEEF, 64'h0, 8'd4, FLAGS_SET));
		send_word(make_word(OP_UNUSED_HI, SZ_64, {64{1'b1}}, {64{1'b1}}, 8'hFF, FLAGS_CLEAR));
		// count masked to zero: no write, flags kept
		send_word(make_word(OP_SHL, SZ_32, 64'h1234_5678, 64'h0, 8'h20, FLAGS_SET));
		// rotate by a multiple of the width still writes back
		send_word(make_word(OP_ROL, SZ_16, 64'h1234, 64'h0, 8'd16, FLAGS_CLEAR));
		// junk above the operand size, and high count bits dropped by the mask
		send_word(make_word(OP_SHR, SZ_8, 64'hFFFF_FFFF_FFFF_FF01, {64{1'b1}}, 8'd1, FLAGS_SET));
		send_word(make_word(OP_ROR, SZ_64, 64'h8000_0000_0000_0001, 64'h0, 8'hFF, FLAGS_CLEAR));
		wait_for_responses();
	endtask

	// Random words in segments, each with its own mix of gaps and stalls
	task automatic test_random_traffic(input int n_words);
		int k;
		for (k = 0; k < n_words; k++) begin
			if (k % 100 == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet <= ($urandom_range(0, 3) == 0);
			end
			send_word(random_word());
		end
		tx_quiet = 1'b0;
	endtask

	// Block the receiver for a long stretch while words keep coming, so the
	// pipe fills and the request side must stall
	task automatic test_receiver_hold();
		tx_quiet = 1'b1;
		rx_quiet <= 1'b0;
		fork
			begin
				rx_block <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_block <= 1'b0;
			end
			repeat (40) send_word(random_word());
		join
		tx_quiet = 1'b0;
	endtask

	// Bursts with no gaps, each followed by a full drain of the pipe
	task automatic test_sender_drain();
		int round;
		tx_quiet = 1'b1;
		for (round = 0; round < 8; round++) begin
			repeat (16) send_word(random_word());
			wait_for_responses();
		end
		tx_quiet = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(1800);
		test_receiver_hold();
		test_sender_drain();

		// Drain, then let the pipe run empty for a while to catch strays
		wait_for_responses();
		repeat (PIPE_LATENCY * 4) @(posedge clk);
		if (pending_rsp.size() != 0)
			report_mismatch($sformatf("%0d words never came back", pending_rsp.size()));

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### x86_shift_rotate_unit.f
design/srot_pkg.sv
design/srot_decode.sv
design/srot_shift.sv
design/srot_flags.sv
design/x86_shift_rotate_unit.sv
design/srot_checker.sv
test/tb_top.sv
